// File: rtl/core/kf_pkg.sv
package kf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W = 32;

    // register indexes
    localparam logic [2:0] REG_DT      = 3'd0;
    localparam logic [2:0] REG_QPOS    = 3'd1;
    localparam logic [2:0] REG_QVEL    = 3'd2;
    localparam logic [2:0] REG_RNOISE  = 3'd3;
    localparam logic [2:0] REG_IPOS    = 3'd4;
    localparam logic [2:0] REG_IVEL    = 3'd5;
    localparam logic [2:0] REG_IVARPOS = 3'd6;
    localparam logic [2:0] REG_IVARVEL = 3'd7;

    // datapath micro-operations, one per controller step
    typedef enum logic [4:0] {
        OP_IDLE   = 5'd0,
        OP_LOAD   = 5'd1,   // optional restart load
        OP_XP     = 5'd2,   // xp  = pos + d*vel
        OP_A00    = 5'd3,   // a00 = pp + d*vp
        OP_A01    = 5'd4,   // a01 = pv + d*vv
        OP_P00    = 5'd5,   // p00 = a00 + a01*d (+q_pos below)
        OP_P00Q   = 5'd6,
        OP_P10    = 5'd7,   // p10 = vp + vv*d, p11 = vv + q_vel
        OP_DIV0   = 5'd8,   // start k0 divide
        OP_DIV0W  = 5'd9,
        OP_DIV1   = 5'd10,  // start k1 divide
        OP_DIV1W  = 5'd11,
        OP_ERR    = 5'd12,  // e = y - xp, omk = 1 - k0
        OP_POS    = 5'd13,
        OP_VEL    = 5'd14,
        OP_CPP    = 5'd15,
        OP_CPV    = 5'd16,
        OP_CVP    = 5'd17,
        OP_CVV    = 5'd18,
        OP_TR     = 5'd19
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

    // saturate a wide signed value to 32 bits
    function automatic logic [W:0] sat64(input logic signed [66:0] v);
        logic signed [66:0] hi;
        logic signed [66:0] lo;
        hi = 67'sd2147483647;
        lo = -67'sd2147483648;
        if (v > hi) sat64 = {1'b1, 32'h7fffffff};
        else if (v < lo) sat64 = {1'b1, 32'h80000000};
        else sat64 = {1'b0, v[W-1:0]};
    endfunction

endpackage

// File: rtl/core/kf_div.sv
// Restoring divider: sign(n)*floor((|n|<<F + R/2)/R), one quotient bit a cycle
module kf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [32:0] o_quo     // {clip, value}
);
    localparam int NW = 32 + kf_pkg::FRAC_BITS;

    logic [NW-1:0] r_dvd;
    logic [NW-1:0] n_dvd;
    logic [31:0]   r_rem;
    logic [31:0]   n_rem;
    logic [30:0]   r_den;
    logic          r_neg;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [31:0]   mag;
    logic [NW-1:0] scaled;
    logic [32:0]   trial;
    logic [30:0]   den_eff;

    always_comb begin
        den_eff = (i_den == 31'd0) ? 31'd1 : i_den;
        mag     = i_num[31] ? (32'd0 - i_num) : i_num;
        scaled  = {mag, {kf_pkg::FRAC_BITS{1'b0}}} + NW'(den_eff >> 1);
        trial   = {r_rem, r_dvd[NW-1]} - {2'b00, r_den};
        if (!trial[32]) begin
            n_rem = trial[31:0];
        end else begin
            n_rem = {r_rem[30:0], r_dvd[NW-1]};
        end
        n_dvd = {r_dvd[NW-2:0], ~trial[32]};
    end

    // iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NW);
                r_dvd  <= scaled;
                r_rem  <= '0;
                r_den  <= den_eff;
                r_neg  <= i_num[31];
            end else if (r_busy) begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign and saturation of the quotient
    always_comb begin
        if (r_neg) begin
            o_quo = kf_pkg::sat64(-$signed({3'b000, 16'd0, r_dvd}));
        end else begin
            o_quo = kf_pkg::sat64($signed({3'b000, 16'd0, r_dvd}));
        end
    end
    assign o_done = r_done;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && i_start)) else $error("divide restarted while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy)) else $error("done while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'(NW)) else $error("count overrun");

endmodule

// File: rtl/core/kf_datapath.sv
// Shared multiply/add datapath with state and config registers
module kf_datapath (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  kf_pkg::t_cmd i_cmd,
    output kf_pkg::t_sts o_sts,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_load_item,
    input  logic [31:0]  i_meas,
    input  logic         i_restart,
    output logic [31:0]  o_pos,
    output logic [31:0]  o_vel,
    output logic [31:0]  o_tr,
    output logic         o_sat
);
    localparam int F = kf_pkg::FRAC_BITS;

    logic [31:0] r_dt, r_ipos, r_ivel;
    logic [30:0] r_qpos, r_qvel, r_rn, r_ivp, r_ivv;
    logic [31:0] r_pos, r_vel, r_pp, r_pv, r_vp, r_vv;
    logic [31:0] r_y, r_xp, r_a00, r_a01, r_p00, r_p10, r_p11, r_k0, r_k1, r_e, r_omk, r_tr;
    logic        r_rs, r_sat;

    logic [31:0] ma, mb, aa;
    logic signed [63:0] prod;
    logic signed [66:0] rnd;
    logic [32:0] mres, ares, sres;
    logic        use_sub;
    logic [31:0] sa, sb;
    logic        div_start;
    logic [31:0] div_num;
    logic        div_done;
    logic [32:0] div_q;
    logic [32:0] omk_v, trv;

    // operand selection: at most one product and one add or subtract per step
    always_comb begin
        ma = r_dt; mb = r_vel; aa = r_pos;
        sa = '0; sb = '0; use_sub = 1'b0;
        div_start = 1'b0; div_num = r_p00;
        case (i_cmd.op)
            kf_pkg::OP_XP:   begin ma = r_dt;  mb = r_vel; aa = r_pos; end
            kf_pkg::OP_A00:  begin ma = r_dt;  mb = r_vp;  aa = r_pp;  end
            kf_pkg::OP_A01:  begin ma = r_dt;  mb = r_vv;  aa = r_pv;  end
            kf_pkg::OP_P00:  begin ma = r_a01; mb = r_dt;  aa = r_a00; end
            kf_pkg::OP_P10:  begin ma = r_vv;  mb = r_dt;  aa = r_vp;  end
            kf_pkg::OP_DIV0: begin div_start = 1'b1; div_num = r_p00; end
            kf_pkg::OP_DIV1: begin div_start = 1'b1; div_num = r_p10; end
            kf_pkg::OP_ERR:  begin sa = r_y; sb = r_xp; use_sub = 1'b1; end
            kf_pkg::OP_POS:  begin ma = r_k0;  mb = r_e;   aa = r_xp;  end
            kf_pkg::OP_VEL:  begin ma = r_k1;  mb = r_e;   aa = r_vel; end
            kf_pkg::OP_CPP:  begin ma = r_omk; mb = r_p00; aa = '0;    end
            kf_pkg::OP_CPV:  begin ma = r_omk; mb = r_a01; aa = '0;    end
            kf_pkg::OP_CVP:  begin ma = r_k1;  mb = r_p00; aa = r_p10; use_sub = 1'b1; end
            kf_pkg::OP_CVV:  begin ma = r_k1;  mb = r_a01; aa = r_p11; use_sub = 1'b1; end
            default: ;
        endcase
    end

    always_comb begin
        prod = $signed(ma) * $signed(mb);
        rnd  = (67'(prod) + (67'sd1 <<< (F - 1))) >>> F;
        mres = kf_pkg::sat64(rnd);
        if (use_sub) begin
            ares = kf_pkg::sat64(67'($signed(aa)) - 67'($signed(mres[31:0])));
        end else begin
            ares = kf_pkg::sat64(67'($signed(aa)) + 67'($signed(mres[31:0])));
        end
        sres = kf_pkg::sat64(67'($signed(sa)) - 67'($signed(sb)));
    end

    kf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_rn),
        .o_done  (div_done),
        .o_quo   (div_q)
    );
    assign o_sts.div_done = div_done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= 32'd655; r_qpos <= 31'd524; r_qvel <= 31'd131072; r_rn <= 31'd65536;
            r_ipos <= '0; r_ivel <= '0; r_ivp <= 31'd65536; r_ivv <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kf_pkg::REG_DT:      r_dt   <= i_cfg_data;
                kf_pkg::REG_QPOS:    r_qpos <= i_cfg_data[30:0];
                kf_pkg::REG_QVEL:    r_qvel <= i_cfg_data[30:0];
                kf_pkg::REG_RNOISE:  r_rn   <= i_cfg_data[30:0];
                kf_pkg::REG_IPOS:    r_ipos <= i_cfg_data;
                kf_pkg::REG_IVEL:    r_ivel <= i_cfg_data;
                kf_pkg::REG_IVARPOS: r_ivp  <= i_cfg_data[30:0];
                kf_pkg::REG_IVARVEL: r_ivv  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // state and temporaries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_vel <= '0; r_pp <= '0; r_pv <= '0; r_vp <= '0; r_vv <= '0;
            r_sat <= 1'b0;
        end else begin
            if (i_load_item) begin
                r_y <= i_meas; r_rs <= i_restart; r_sat <= 1'b0;
            end
            case (i_cmd.op)
                kf_pkg::OP_LOAD: if (r_rs) begin
                    r_pos <= r_ipos; r_vel <= r_ivel;
                    r_pp <= {1'b0, r_ivp}; r_pv <= '0; r_vp <= '0; r_vv <= {1'b0, r_ivv};
                end
                kf_pkg::OP_XP:  begin r_xp <= ares[31:0]; r_sat <= r_sat | mres[32] | ares[32]; end
                kf_pkg::OP_A00: begin r_a00 <= ares[31:0]; r_sat <= r_sat | mres[32] | ares[32]; end
                kf_pkg::OP_A01: begin r_a01 <= ares[31:0]; r_sat <= r_sat | mres[32] | ares[32]; end
                kf_pkg::OP_P00: begin r_p00 <= ares[31:0]; r_sat <= r_sat | mres[32] | ares[32]; end
                kf_pkg::OP_P00Q: begin
                    r_p00 <= sres_q(r_p00, r_qpos);
                    r_sat <= r_sat | satq(r_p00, r_qpos);
                end
                kf_pkg::OP_P10: begin
                    r_p10 <= ares[31:0];
                    r_p11 <= sres_q(r_vv, r_qvel);
                    r_sat <= r_sat | mres[32] | ares[32] | satq(r_vv, r_qvel);
                end
                kf_pkg::OP_DIV0W: if (div_done) begin
                    r_k0 <= div_q[31:0]; r_sat <= r_sat | div_q[32];
                end
                kf_pkg::OP_DIV1W: if (div_done) begin
                    r_k1 <= div_q[31:0]; r_sat <= r_sat | div_q[32];
                end
                kf_pkg::OP_ERR: begin
                    r_e   <= sres[31:0];
                    r_omk <= omk_v[31:0];
                    r_sat <= r_sat | sres[32] | omk_v[32];
                end
                kf_pkg::OP_POS: begin r_pos <= ares[31:0]; r_sat <= r_sat | mres[32] | ares[32]; end
                kf_pkg::OP_VEL: begin r_vel <= ares[31:0]; r_sat <= r_sat | mres[32] | ares[32]; end
                kf_pkg::OP_CPP: begin r_pp <= mres[31:0]; r_sat <= r_sat | mres[32]; end
                kf_pkg::OP_CPV: begin r_pv <= mres[31:0]; r_sat <= r_sat | mres[32]; end
                kf_pkg::OP_CVP: begin r_vp <= ares[31:0]; r_sat <= r_sat | mres[32] | ares[32]; end
                kf_pkg::OP_CVV: begin r_vv <= ares[31:0]; r_sat <= r_sat | mres[32] | ares[32]; end
                kf_pkg::OP_TR:  begin r_tr <= trv[31:0]; r_sat <= r_sat | trv[32]; end
                default: ;
            endcase
        end
    end

    always_comb begin
        omk_v = kf_pkg::sat64((67'sd1 <<< F) - 67'($signed(r_k0)));
        trv   = kf_pkg::sat64(67'($signed(r_pp)) + 67'($signed(r_vv)));
    end

    function automatic logic [31:0] sres_q(input logic [31:0] a, input logic [30:0] b);
        logic [32:0] t;
        t = kf_pkg::sat64(67'($signed(a)) + 67'(b));
        sres_q = t[31:0];
    endfunction

    function automatic logic satq(input logic [31:0] a, input logic [30:0] b);
        logic [32:0] t;
        t = kf_pkg::sat64(67'($signed(a)) + 67'(b));
        satq = t[32];
    endfunction

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_tr  = r_tr;
    assign o_sat = r_sat;

endmodule

// File: rtl/core/kf_ctrl.sv
// Sequencer: walks the datapath through one filter step
module kf_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    output logic         o_load_item,
    output kf_pkg::t_cmd o_cmd,
    input  kf_pkg::t_sts i_sts,
    output logic         o_out_valid,
    input  logic         i_out_ready
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state     r_state, n_state;
    kf_pkg::t_op r_op, n_op;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_load_item = o_in_ready && i_in_valid;
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.op    = (r_state == S_RUN) ? r_op : kf_pkg::OP_IDLE;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_state = S_RUN;
                n_op    = kf_pkg::OP_LOAD;
            end
            S_RUN: begin
                case (r_op)
                    kf_pkg::OP_DIV0W, kf_pkg::OP_DIV1W: begin
                        if (i_sts.div_done) n_op = kf_pkg::t_op'(r_op + 5'd1);
                    end
                    kf_pkg::OP_TR: n_state = S_OUT;
                    default: n_op = kf_pkg::t_op'(r_op + 5'd1);
                endcase
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= kf_pkg::OP_IDLE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    property p_done_in_wait;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_sts.div_done |-> (r_op == kf_pkg::OP_DIV0W || r_op == kf_pkg::OP_DIV1W);
    endproperty
    a_done_in_wait: assert property (p_done_in_wait) else $error("divide done out of place");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load_item |=> (r_state == S_RUN && r_op == kf_pkg::OP_LOAD))
        else $error("accept did not start step");

endmodule

// File: rtl/core/kalman_filter_pos_vel_core.sv
// Two-state (position, velocity) Kalman filter, signed Q16.16.
// Channels: s_axis carries one measurement per transaction, with the
// restart flag on tuser; m_axis returns position, velocity and covariance
// trace on tdata with the saturation flag on tuser. A separate write
// channel (cfg_valid/cfg_ready, index, data) sets the eight registers.
// Each transaction passes from accept to result valid through 17
// sequencer steps on one shared multiplier and adder, plus two
// restoring divides of one quotient bit a cycle, each ending in a done
// strobe, that dominate the step. One item is in flight at a time; the
// result handshake follows, and only after the return to idle is the
// next transaction accepted.
// Reset (synchronous, active low) clears state to zero and loads register
// defaults. If the receiver stalls, the result holds on m_axis and no new
// transaction is accepted until it is taken.
module kalman_filter_pos_vel_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] measurement
    input  logic         s_axis_tuser,   // [0] restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [31:0] est_pos, [63:32] est_vel, [95:64] cov_trace
    output logic         m_axis_tuser,   // [0] saturated
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    kf_pkg::t_cmd cmd;
    kf_pkg::t_sts sts;
    logic         load_item;
    logic [31:0]  pos, vel, tr;

    assign o_cfg_ready = 1'b1;

    kf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_load_item (load_item),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    kf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_idx   (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load_item (load_item),
        .i_meas      (s_axis_tdata),
        .i_restart   (s_axis_tuser),
        .o_pos       (pos),
        .o_vel       (vel),
        .o_tr        (tr),
        .o_sat       (m_axis_tuser)
    );

    assign m_axis_tdata = {tr, vel, pos};

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // saturating fixed-point helpers for the filter predictor
    class kf_scoreboard;
        longint dt, qp, qv, rn, ipos, ivel, ivp, ivv;
        longint pos, vel, pp, pv, vp, vv;
        bit clip;
        bit [96:0] pending[$];
        int errors;

        function new();
            dt = 655; qp = 524; qv = 131072; rn = 65536;
            ipos = 0; ivel = 0; ivp = 65536; ivv = 65536;
            pos = 0; vel = 0; pp = 0; pv = 0; vp = 0; vv = 0;
            errors = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) begin
                clip = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                clip = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint qmul(longint a, longint b);
            longint p;
            p = a * b + (64'sd1 <<< (kf_pkg::FRAC_BITS - 1));
            return sat(p >>> kf_pkg::FRAC_BITS);
        endfunction

        function longint qdiv(longint n, longint d);
            longint mag, q;
            mag = (n < 0) ? -n : n;
            q = ((mag <<< kf_pkg::FRAC_BITS) + d / 2) / d;
            return sat(n < 0 ? -q : q);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                kf_pkg::REG_DT:      dt = longint'($signed(v));
                kf_pkg::REG_QPOS:    qp = v[30:0];
                kf_pkg::REG_QVEL:    qv = v[30:0];
                kf_pkg::REG_RNOISE:  rn = v[30:0];
                kf_pkg::REG_IPOS:    ipos = longint'($signed(v));
                kf_pkg::REG_IVEL:    ivel = longint'($signed(v));
                kf_pkg::REG_IVARPOS: ivp = v[30:0];
                kf_pkg::REG_IVARVEL: ivv = v[30:0];
                default: ;
            endcase
        endfunction

        // one filter step: restart, predict, gain, update
        function void note_measurement(logic [31:0] meas, logic restart);
            longint y, r, a00, a01, p00, p01, p10, p11, xp, xv, k0, k1, e, omk, tr;
            y = longint'($signed(meas));
            r = (rn > 0) ? rn : 1;
            clip = 0;
            if (restart) begin
                pos = ipos; vel = ivel; pp = ivp; pv = 0; vp = 0; vv = ivv;
            end
            xp = sat(pos + qmul(dt, vel));
            xv = vel;
            a00 = sat(pp + qmul(dt, vp));
            a01 = sat(pv + qmul(dt, vv));
            p00 = sat(sat(a00 + qmul(a01, dt)) + qp);
            p01 = a01;
            p10 = sat(vp + qmul(vv, dt));
            p11 = sat(vv + qv);
            k0 = qdiv(p00, r);
            k1 = qdiv(p10, r);
            e = sat(y - xp);
            pos = sat(xp + qmul(k0, e));
            vel = sat(xv + qmul(k1, e));
            omk = sat((64'sd1 <<< kf_pkg::FRAC_BITS) - k0);
            pp = qmul(omk, p00);
            pv = qmul(omk, p01);
            vp = sat(p10 - qmul(k1, p00));
            vv = sat(p11 - qmul(k1, p01));
            tr = sat(pp + vv);
            pending.push_back({clip, tr[31:0], vel[31:0], pos[31:0]});
        endfunction

        task check_estimate(logic [95:0] data, logic flag);
            bit [96:0] exp_v;
            if (pending.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            exp_v = pending.pop_front();
            if (data[31:0] !== exp_v[31:0])
                report($sformatf("est_pos %h want %h", data[31:0], exp_v[31:0]));
            if (data[63:32] !== exp_v[63:32])
                report($sformatf("est_vel %h want %h", data[63:32], exp_v[63:32]));
            if (data[95:64] !== exp_v[95:64])
                report($sformatf("cov_trace %h want %h", data[95:64], exp_v[95:64]));
            if (flag !== exp_v[96])
                report($sformatf("saturated %b want %b", flag, exp_v[96]));
        endtask

        task report(string msg);
            errors++;
            if (errors <= 50) $display("mismatch: %s", msg);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;

    kf_scoreboard sb = new();
    int hold_cycles = 0;

    kalman_filter_pos_vel_core dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // sample results at the edge, before the driven values change
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_estimate(m_axis_tdata, m_axis_tuser);
    end

    // receiver: stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 0;
        end else begin
            case ($urandom_range(0, 3))
                0: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= 1;
            endcase
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
        i_cfg_valid <= 0;
    endtask

    task automatic send_measurement(logic [31:0] meas, logic restart);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= meas;
        s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_measurement(meas, restart);
    endtask

    task automatic gap();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
        endcase
    endfunction

    // random burst phase; restarts are sparse so the filter converges
    task automatic burst_phase(int n);
        int sent, len;
        sent = 0;
        while (sent < n) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len && sent < n; k++) begin
                send_measurement(rand_meas(), $urandom_range(0, 19) == 0);
                sent++;
            end
            if ($urandom_range(0, 2) == 0) gap();
        end
        drain();
    endtask

    task automatic random_regs();
        write_reg(kf_pkg::REG_DT,
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 131072));
        write_reg(kf_pkg::REG_QPOS,
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 200000));
        write_reg(kf_pkg::REG_QVEL,
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 200000));
        write_reg(kf_pkg::REG_RNOISE,
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 500000));
        write_reg(kf_pkg::REG_IPOS, $urandom());
        write_reg(kf_pkg::REG_IVEL,
                  $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 200000));
        write_reg(kf_pkg::REG_IVARPOS,
                  $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 300000));
        write_reg(kf_pkg::REG_IVARVEL,
                  $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 300000));
    endtask

    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero reset state without restart, extremes of measurement
        send_measurement(32'h0000_0000, 0);
        send_measurement(32'h7fff_ffff, 0);
        send_measurement(32'h8000_0000, 0);
        send_measurement(32'h0001_0000, 1);
        send_measurement(32'hffff_0000, 0);
        drain();

        // extreme registers, zero noise used as one
        write_reg(kf_pkg::REG_DT, 32'h7fff_ffff);
        write_reg(kf_pkg::REG_QPOS, 32'h7fff_ffff);
        write_reg(kf_pkg::REG_QVEL, 32'h7fff_ffff);
        write_reg(kf_pkg::REG_RNOISE, 32'h0000_0000);
        write_reg(kf_pkg::REG_IPOS, 32'h8000_0000);
        write_reg(kf_pkg::REG_IVEL, 32'h7fff_ffff);
        write_reg(kf_pkg::REG_IVARPOS, 32'hffff_ffff);
        write_reg(kf_pkg::REG_IVARVEL, 32'hffff_ffff);
        send_measurement(32'h7fff_ffff, 1);
        send_measurement(32'h8000_0000, 0);
        send_measurement(32'h1234_5678, 1);
        drain();
        write_reg(kf_pkg::REG_DT, 32'h8000_0000);
        write_reg(kf_pkg::REG_RNOISE, 32'h0000_0001);
        write_reg(kf_pkg::REG_QPOS, 32'h0);
        write_reg(kf_pkg::REG_QVEL, 32'h0);
        write_reg(kf_pkg::REG_IPOS, 32'h7fff_ffff);
        write_reg(kf_pkg::REG_IVEL, 32'h8000_0000);
        write_reg(kf_pkg::REG_IVARPOS, 32'h0);
        write_reg(kf_pkg::REG_IVARVEL, 32'h0);
        send_measurement(32'h8000_0000, 1);
        send_measurement(32'h0000_0001, 0);
        send_measurement(32'hdead_beef, 1);
        drain();

        // back to the defaults, then a long receiver hold-off under load
        write_reg(kf_pkg::REG_DT, 655);
        write_reg(kf_pkg::REG_QPOS, 524);
        write_reg(kf_pkg::REG_QVEL, 131072);
        write_reg(kf_pkg::REG_RNOISE, 65536);
        write_reg(kf_pkg::REG_IPOS, 0);
        write_reg(kf_pkg::REG_IVEL, 0);
        write_reg(kf_pkg::REG_IVARPOS, 65536);
        write_reg(kf_pkg::REG_IVARVEL, 65536);
        hold_cycles <= 400;
        for (int k = 0; k < 8; k++) send_measurement(rand_meas(), k == 0);
        drain();
        burst_phase(400);

        for (int ph = 0; ph < 5; ph++) begin
            random_regs();
            burst_phase(280);
        end

        if (sb.errors == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end
endmodule
